// ===== sv/sprd_pkg.sv =====
package sprd_pkg;

  // Width of the pen coordinates; the ports always carry 16 bits.
  localparam int CoordBits = 16;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_LITERAL,
    PH_SHADOW_CNT,
    PH_SHADOW_EXT,
    PH_FILL_CNT,
    PH_FILL_COLOUR
  } phase_t;

  localparam logic [1:0] KindPalette = 2'd0;
  localparam logic [1:0] KindShadow  = 2'd1;
  localparam logic [1:0] KindNone    = 2'd2;

  localparam logic [1:0] StatusRunning = 2'd0;
  localparam logic [1:0] StatusEndMark = 2'd1;
  localparam logic [1:0] StatusRanOut  = 2'd2;

  localparam logic [1:0] RegImageWidth   = 2'd0;
  localparam logic [1:0] RegMirror       = 2'd1;
  localparam logic [1:0] RegShadowEnable = 2'd2;

  localparam logic [7:0] OpEndLine = 8'h00;
  localparam logic [7:0] OpEndMark = 8'h80;
  localparam logic [7:0] OpShadow  = 8'hC0;
  localparam logic [7:0] OpFill    = 8'hC1;

  localparam logic [15:0] ImageWidthReset = 16'd64;

  typedef struct packed {
    logic [15:0] image_width;
    logic        mirror;
    logic        shadow_enable;
  } cfg_t;

  typedef struct packed {
    logic [CoordBits-1:0] pen_column;
    logic [CoordBits-1:0] pen_row;
    phase_t               phase;
    logic [7:0]           run_count;
    logic                 finished;
  } state_t;

  typedef struct packed {
    logic [1:0]  span_kind;
    logic [15:0] start_column;
    logic [15:0] row;
    logic [7:0]  span_length;
    logic [7:0]  colour_index;
    logic [1:0]  stream_status;
  } result_t;

  // Pen step: rightwards normally, leftwards when mirrored, wrapping.
  function automatic logic [CoordBits-1:0] move_pen(input logic [CoordBits-1:0] col,
                                                    input logic [7:0] n,
                                                    input logic mirror);
    logic [CoordBits-1:0] step;
    step = CoordBits'(n);
    return mirror ? (col - step) : (col + step);
  endfunction

  function automatic logic [CoordBits-1:0] row_start(input cfg_t cfg);
    logic [15:0] wm1;
    wm1 = cfg.image_width - 16'd1;
    return cfg.mirror ? wm1[CoordBits-1:0] : '0;
  endfunction

endpackage

// ===== sv/sprd_if.sv =====
interface sprd_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface sprd_span_if;
  logic        valid;
  logic        ready;
  logic [1:0]  span_kind;
  logic [15:0] start_column;
  logic [15:0] row;
  logic [7:0]  span_length;
  logic [7:0]  colour_index;
  logic [1:0]  stream_status;

  modport source (output valid, span_kind, start_column, row, span_length, colour_index,
                  stream_status, input ready);
  modport sink   (input valid, span_kind, start_column, row, span_length, colour_index,
                  stream_status, output ready);
endinterface

interface sprd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== sv/sprite_rle_span_decoder_core.sv =====
// Run-length sprite span decoder.
// The code channel takes one word per cycle: a byte of the coded sprite with
// flags for the first and the last byte of a buffer. The span channel gives
// at most one word for each code word: a palette span, a shadow span, or a
// status-only word when the end mark is met or the buffer runs out.
// The cfg channel writes image width, mirror and shadow enable; it is always
// ready and should only be used while no code word is still in flight.
// A code word enters the input register when accepted; its span word is then
// loaded into the span register once the decode stage moves, and shown there.
// One code word is accepted every cycle while the span
// side keeps up; the whole byte decode sits between an input register and
// the span register, so the pen and phase are settled before the next byte.
// When the receiver stalls, the span word holds and the input register holds
// the following byte; the code channel then stalls one word later.
// Reset clears the pen, the phase and the finished flag, loads the register
// defaults (width 64, no mirroring, shadows drawn) and empties both stages.
module sprite_rle_span_decoder_core (
  input logic         clk,
  input logic         rst,
  sprd_code_if.sink   code,
  sprd_span_if.source span,
  sprd_cfg_if.sink    cfg
);

  sprd_pkg::cfg_t    cfg_q;
  sprd_pkg::state_t  st;
  sprd_pkg::state_t  st_next;
  sprd_pkg::result_t res;
  sprd_pkg::result_t out_q;
  logic              emit;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       s1_last;

  logic out_valid;
  logic adv;

  // The decode stage moves whenever the span register is empty or being taken.
  assign adv        = !out_valid || span.ready;
  assign code.ready = !s1_valid || adv;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.image_width   <= sprd_pkg::ImageWidthReset;
      cfg_q.mirror        <= 1'b0;
      cfg_q.shadow_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        sprd_pkg::RegImageWidth:   cfg_q.image_width   <= cfg.wdata;
        sprd_pkg::RegMirror:       cfg_q.mirror        <= cfg.wdata[0];
        sprd_pkg::RegShadowEnable: cfg_q.shadow_enable <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (code.ready) begin
      s1_valid <= code.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code.ready && code.valid) begin
      s1_byte  <= code.data_byte;
      s1_first <= code.first_byte;
      s1_last  <= code.last_byte;
    end
  end

  sprd_decode u_decode (
    .st         (st),
    .cfg        (cfg_q),
    .data_byte  (s1_byte),
    .first_byte (s1_first),
    .last_byte  (s1_last),
    .st_next    (st_next),
    .emit       (emit),
    .res        (res)
  );

  // Decoder state only changes when a byte leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.pen_column <= '0;
      st.pen_row    <= '0;
      st.phase      <= sprd_pkg::PH_OPCODE;
      st.run_count  <= '0;
      st.finished   <= 1'b0;
    end else if (s1_valid && adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid && emit) begin
      out_q <= res;
    end
  end

  assign span.valid         = out_valid;
  assign span.span_kind     = out_q.span_kind;
  assign span.start_column  = out_q.start_column;
  assign span.row           = out_q.row;
  assign span.span_length   = out_q.span_length;
  assign span.colour_index  = out_q.colour_index;
  assign span.stream_status = out_q.stream_status;

  // A decoded last byte always leaves the decoder finished.
  a_last_finishes: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv && s1_last) |=> st.finished)
    else $error("last byte did not finish the stream");

  // A stalled decode stage keeps its byte.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_byte) && $stable(s1_first)))
    else $error("input register lost a byte under stall");

  // A literal run in progress never has a zero count.
  a_literal_count: assert property (@(posedge clk) disable iff (rst)
    (st.phase == sprd_pkg::PH_LITERAL) |-> (st.run_count != 8'd0))
    else $error("literal phase with zero count");

  // End-mark words never carry a span.
  a_endmark_nospan: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.stream_status == sprd_pkg::StatusEndMark)
      |-> (out_q.span_kind == sprd_pkg::KindNone && out_q.span_length == 8'd0))
    else $error("end mark word carries a span");

endmodule

// ===== sv/sprd_decode.sv =====
module sprd_decode (
  input  sprd_pkg::state_t  st,
  input  sprd_pkg::cfg_t    cfg,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  output sprd_pkg::state_t  st_next,
  output logic              emit,
  output sprd_pkg::result_t res
);

  sprd_pkg::state_t     eff;
  sprd_pkg::phase_t     phase_next;
  logic [7:0]           count_next;
  logic [7:0]           count_dec;
  logic [7:0]           n;
  logic                 do_move;
  logic                 end_line;
  logic                 end_mark;
  logic                 span;
  logic [1:0]           kind;
  logic [7:0]           colour;
  logic [sprd_pkg::CoordBits-1:0] col_next;
  logic [sprd_pkg::CoordBits-1:0] row_next;

  // A first byte restarts the pen and the decoder before being decoded.
  always_comb begin
    eff = st;
    if (first_byte) begin
      eff.pen_row    = '0;
      eff.pen_column = sprd_pkg::row_start(cfg);
      eff.phase      = sprd_pkg::PH_OPCODE;
      eff.run_count  = '0;
      eff.finished   = 1'b0;
    end
  end

  assign count_dec = eff.run_count - 8'd1;

  // Phase and run count.
  always_comb begin
    phase_next = eff.phase;
    count_next = eff.run_count;
    if (!eff.finished) begin
      case (eff.phase)
        sprd_pkg::PH_OPCODE: begin
          if (data_byte inside {[8'h01:8'h7F]}) begin
            count_next = data_byte;
            phase_next = sprd_pkg::PH_LITERAL;
          end else if (data_byte == sprd_pkg::OpShadow) begin
            phase_next = sprd_pkg::PH_SHADOW_CNT;
          end else if (data_byte == sprd_pkg::OpFill) begin
            phase_next = sprd_pkg::PH_FILL_CNT;
          end else if (data_byte inside {[8'hC2:8'hFF]}) begin
            count_next = data_byte - sprd_pkg::OpShadow;
            phase_next = sprd_pkg::PH_FILL_COLOUR;
          end
        end
        sprd_pkg::PH_LITERAL: begin
          count_next = count_dec;
          if (count_dec == 8'd0) begin
            phase_next = sprd_pkg::PH_OPCODE;
          end
        end
        sprd_pkg::PH_SHADOW_CNT: begin
          phase_next = (data_byte[1:0] != 2'd0) ? sprd_pkg::PH_OPCODE
                                                 : sprd_pkg::PH_SHADOW_EXT;
        end
        sprd_pkg::PH_SHADOW_EXT: begin
          phase_next = sprd_pkg::PH_OPCODE;
        end
        sprd_pkg::PH_FILL_CNT: begin
          count_next = data_byte;
          phase_next = sprd_pkg::PH_FILL_COLOUR;
        end
        sprd_pkg::PH_FILL_COLOUR: begin
          count_next = '0;
          phase_next = sprd_pkg::PH_OPCODE;
        end
        default: begin
          phase_next = sprd_pkg::PH_OPCODE;
        end
      endcase
    end
  end

  // Pen movement and span generation.
  always_comb begin
    n        = '0;
    do_move  = 1'b0;
    end_line = 1'b0;
    end_mark = 1'b0;
    span     = 1'b0;
    kind     = sprd_pkg::KindNone;
    colour   = '0;
    if (!eff.finished) begin
      case (eff.phase)
        sprd_pkg::PH_OPCODE: begin
          if (data_byte == sprd_pkg::OpEndLine) begin
            end_line = 1'b1;
          end else if (data_byte == sprd_pkg::OpEndMark) begin
            end_mark = 1'b1;
          end else if (data_byte inside {[8'h81:8'hBF]}) begin
            n       = data_byte - sprd_pkg::OpEndMark;
            do_move = 1'b1;
          end
        end
        sprd_pkg::PH_LITERAL: begin
          n       = 8'd1;
          do_move = 1'b1;
          span    = 1'b1;
          kind    = sprd_pkg::KindPalette;
          colour  = data_byte;
        end
        sprd_pkg::PH_SHADOW_CNT: begin
          if (data_byte[1:0] != 2'd0) begin
            n       = {6'd0, data_byte[1:0]};
            do_move = 1'b1;
            span    = cfg.shadow_enable;
            kind    = sprd_pkg::KindShadow;
          end
        end
        sprd_pkg::PH_SHADOW_EXT: begin
          n       = data_byte;
          do_move = 1'b1;
          span    = cfg.shadow_enable && (data_byte != 8'd0);
          kind    = sprd_pkg::KindShadow;
        end
        sprd_pkg::PH_FILL_COLOUR: begin
          n       = eff.run_count;
          do_move = 1'b1;
          span    = (eff.run_count != 8'd0);
          kind    = sprd_pkg::KindPalette;
          colour  = data_byte;
        end
        default: begin
          n = '0;
        end
      endcase
    end
  end

  always_comb begin
    col_next = eff.pen_column;
    row_next = eff.pen_row;
    if (end_line) begin
      row_next = eff.pen_row + sprd_pkg::CoordBits'(1);
      col_next = sprd_pkg::row_start(cfg);
    end else if (do_move) begin
      col_next = sprd_pkg::move_pen(eff.pen_column, n, cfg.mirror);
    end
  end

  always_comb begin
    st_next            = eff;
    st_next.pen_column = col_next;
    st_next.pen_row    = row_next;
    st_next.phase      = phase_next;
    st_next.run_count  = count_next;
    st_next.finished   = eff.finished || end_mark || last_byte;
  end

  // One result at most: an end mark wins; a span and running out share one word.
  always_comb begin
    emit              = 1'b0;
    res.span_kind     = sprd_pkg::KindNone;
    res.start_column  = 16'(col_next);
    res.row           = 16'(row_next);
    res.span_length   = '0;
    res.colour_index  = '0;
    res.stream_status = sprd_pkg::StatusRunning;
    if (!eff.finished) begin
      if (end_mark) begin
        emit              = 1'b1;
        res.stream_status = sprd_pkg::StatusEndMark;
      end else if (span || last_byte) begin
        emit = 1'b1;
        if (span) begin
          res.span_kind    = kind;
          res.start_column = 16'(eff.pen_column);
          res.span_length  = n;
          res.colour_index = colour;
        end
        res.stream_status = last_byte ? sprd_pkg::StatusRanOut : sprd_pkg::StatusRunning;
      end
    end
  end

endmodule
